>>> src/gosa_pkg.sv
// Shared types and constants for the operand swizzle address generator.
// Used by every module under src; no dependencies of its own.
package gosa_pkg;

  // Largest legal tile dimension
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned PAD_W   = 12;
  localparam int unsigned OFF_W   = 21;
  localparam int unsigned TC_W    = 6;
  localparam int unsigned TR_W    = 8;
  localparam int unsigned SWZ_W   = 10;

  // Register map
  localparam logic [1:0] REG_ELEM_SIZE   = 2'd0;
  localparam logic [1:0] REG_K_FACTOR    = 2'd1;
  localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_TILE_HEIGHT = 2'd3;

  // Element size codes and k-factor values
  localparam logic [1:0] ESC_8  = 2'd0;
  localparam logic [1:0] ESC_16 = 2'd1;
  localparam logic [1:0] ESC_64 = 2'd3;
  localparam logic [1:0] KF_OUTER = 2'd1;
  localparam logic [1:0] KF_INNER = 2'd2;

  typedef enum logic [2:0] {
    KIND_FULL       = 3'd0,
    KIND_HALF       = 3'd1,
    KIND_F64_KOUTER = 3'd2,
    KIND_F64_KINNER = 3'd3,
    KIND_PADDED     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]       elem_size;
    logic [1:0]       k_factor;
    logic [DIM_W-1:0] tile_width;
    logic [DIM_W-1:0] tile_height;
  } cfg_t;

  // Stage 1 -> stage 2
  typedef struct packed {
    kind_t            kind;
    logic             err;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [1:0]       elem_size;
    logic [PAD_W-1:0] padded;
  } dec_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    kind_t            kind;
    logic             err;
    logic [TC_W-1:0]  tile_col;
    logic [TR_W-1:0]  tile_row;
    logic [SWZ_W-1:0] swz_off;
    logic [OFF_W-1:0] prod;
    logic [IDX_W-1:0] col;
  } map_t;

endpackage

>>> src/gemm_operand_swizzle_address_top.sv
// Operand tile swizzle address generator: (row, col) to layout kind, tile and offset.
// Pipeline: registered decode, map and output stages between input transaction and result valid.
// Throughput: one transaction per cycle; each stage holds under back-pressure.
// Reset (rst_n, synchronous): pipeline valids clear; registers return to 16-bit
// elements, k outer, 64 x 64 tile. Depends on gosa_pkg and the gosa_* stages.
module gemm_operand_swizzle_address_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] row, [19:10] col, [23:20] zero
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] tile_col, [13:6] tile_row, [34:14] offset, [39:35] zero
  output logic [3:0]  out_tuser,  // [2:0] layout_kind, [3] error
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  gosa_pkg::cfg_t             cfg;
  logic                       dec_valid;
  logic                       dec_ready;
  gosa_pkg::dec_t             dec_data;
  logic                       map_valid;
  logic                       map_ready;
  gosa_pkg::map_t             map_data;
  gosa_pkg::kind_t            res_kind;
  logic [gosa_pkg::TC_W-1:0]  res_tile_col;
  logic [gosa_pkg::TR_W-1:0]  res_tile_row;
  logic [gosa_pkg::OFF_W-1:0] res_offset;
  logic                       res_err;

  gosa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  gosa_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .row      (in_tdata[9:0]),
    .col      (in_tdata[19:10]),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  gosa_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (map_valid),
    .dn_ready (map_ready),
    .dn_data  (map_data)
  );

  gosa_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (map_valid),
    .up_ready (map_ready),
    .up_data  (map_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .kind     (res_kind),
    .tile_col (res_tile_col),
    .tile_row (res_tile_row),
    .offset   (res_offset),
    .err      (res_err)
  );

  // Pack result fields
  assign out_tdata = {5'd0, res_offset, res_tile_row, res_tile_col};
  assign out_tuser = {res_err, res_kind};

endmodule

>>> src/gosa_cfg.sv
// Configuration registers behind an APB-style write/read port.
// Depends on gosa_pkg for the register map and cfg_t.
module gosa_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output gosa_pkg::cfg_t      cfg
);

  gosa_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Write selected register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.elem_size   <= gosa_pkg::ESC_16;
      cfg_r.k_factor    <= gosa_pkg::KF_OUTER;
      cfg_r.tile_width  <= gosa_pkg::DIM_W'(64);
      cfg_r.tile_height <= gosa_pkg::DIM_W'(64);
    end else if (wr_en) begin
      case (paddr[3:2])
        gosa_pkg::REG_ELEM_SIZE:   cfg_r.elem_size   <= pwdata[1:0];
        gosa_pkg::REG_K_FACTOR:    cfg_r.k_factor    <= pwdata[1:0];
        gosa_pkg::REG_TILE_WIDTH:  cfg_r.tile_width  <= pwdata[gosa_pkg::DIM_W-1:0];
        gosa_pkg::REG_TILE_HEIGHT: cfg_r.tile_height <= pwdata[gosa_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back selected register
  always_comb begin
    case (paddr[3:2])
      gosa_pkg::REG_ELEM_SIZE:   prdata = 32'(cfg_r.elem_size);
      gosa_pkg::REG_K_FACTOR:    prdata = 32'(cfg_r.k_factor);
      gosa_pkg::REG_TILE_WIDTH:  prdata = 32'(cfg_r.tile_width);
      gosa_pkg::REG_TILE_HEIGHT: prdata = 32'(cfg_r.tile_height);
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

>>> src/gosa_decode.sv
// Stage 1: layout selection, range and stride checks, padded row width.
// Depends on gosa_pkg for cfg_t, dec_t and the layout kinds.
module gosa_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gosa_pkg::cfg_t             cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [gosa_pkg::IDX_W-1:0] row,
  input  logic [gosa_pkg::IDX_W-1:0] col,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output gosa_pkg::dec_t             dn_data
);

  logic                       valid_r;
  gosa_pkg::dec_t             data_r;
  gosa_pkg::dec_t             data_nxt;
  gosa_pkg::kind_t            kind;
  logic [gosa_pkg::DIM_W-1:0] full_mask;
  logic [gosa_pkg::DIM_W-1:0] half_mask;
  logic [gosa_pkg::DIM_W-1:0] pad_mask;
  logic [4:0]                 vec;
  logic                       kf_bad;
  logic                       dim_bad;
  logic                       idx_bad;
  logic                       stride_bad;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Width masks: multiple of 8 vectors, 4 vectors, 256 bits
  assign full_mask = gosa_pkg::DIM_W'(127) >> cfg.elem_size;
  assign half_mask = gosa_pkg::DIM_W'(63) >> cfg.elem_size;
  assign pad_mask  = gosa_pkg::DIM_W'(31) >> cfg.elem_size;
  assign vec       = 5'd16 >> cfg.elem_size;

  // Pick the layout
  always_comb begin
    if (cfg.elem_size == gosa_pkg::ESC_64) begin
      if (cfg.tile_width[3:0] != 4'd0)           kind = gosa_pkg::KIND_PADDED;
      else if (cfg.k_factor == gosa_pkg::KF_OUTER) kind = gosa_pkg::KIND_F64_KOUTER;
      else if (cfg.k_factor == gosa_pkg::KF_INNER) kind = gosa_pkg::KIND_F64_KINNER;
      else                                          kind = gosa_pkg::KIND_PADDED;
    end else if (cfg.k_factor == gosa_pkg::KF_OUTER && cfg.elem_size == gosa_pkg::ESC_8) begin
      kind = gosa_pkg::KIND_PADDED;
    end else if ((cfg.tile_width & full_mask) == '0) begin
      kind = gosa_pkg::KIND_FULL;
    end else if ((cfg.tile_width & half_mask) == '0) begin
      kind = gosa_pkg::KIND_HALF;
    end else begin
      kind = gosa_pkg::KIND_PADDED;
    end
  end

  // Error conditions
  assign kf_bad  = (cfg.k_factor != gosa_pkg::KF_OUTER) && (cfg.k_factor != gosa_pkg::KF_INNER);
  assign dim_bad = (cfg.tile_width == '0) ||
                   (cfg.tile_width > gosa_pkg::DIM_W'(gosa_pkg::MAX_DIM)) ||
                   (cfg.tile_height == '0) ||
                   (cfg.tile_height > gosa_pkg::DIM_W'(gosa_pkg::MAX_DIM));
  assign idx_bad = ({1'b0, row} >= cfg.tile_height) || ({1'b0, col} >= cfg.tile_width);
  assign stride_bad = ((kind == gosa_pkg::KIND_FULL) || (kind == gosa_pkg::KIND_HALF)) &&
                      (cfg.tile_height[2:0] != 3'd0);

  always_comb begin
    data_nxt.kind      = kind;
    data_nxt.err       = kf_bad || dim_bad || idx_bad || stride_bad;
    data_nxt.row       = row;
    data_nxt.col       = col;
    data_nxt.elem_size = cfg.elem_size;
    // Add one vector of padding when a row is a multiple of 256 bits
    data_nxt.padded    = {1'b0, cfg.tile_width} +
                         (((cfg.tile_width & pad_mask) == '0) ?
                          gosa_pkg::PAD_W'(vec) : gosa_pkg::PAD_W'(0));
  end

  // Advance stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> src/gosa_map.sv
// Stage 2: swizzle math for the four swizzled layouts and the padded product.
// Depends on gosa_pkg for dec_t, map_t and the layout kinds.
module gosa_map (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  gosa_pkg::dec_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output gosa_pkg::map_t dn_data
);

  logic                       valid_r;
  gosa_pkg::map_t             data_r;
  gosa_pkg::map_t             data_nxt;
  logic [2:0]                 lv;
  logic [gosa_pkg::IDX_W-1:0] vidx;
  logic [gosa_pkg::IDX_W-1:0] col_low;
  logic [2:0]                 s8;
  logic [1:0]                 s4;
  logic [3:0]                 c16;
  logic [2:0]                 c8;
  logic [1:0]                 c4;
  logic [21:0]                prod;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Vector index and position inside the vector
  assign lv      = 3'(3'd4 - {1'b0, up_data.elem_size});
  assign vidx    = up_data.col >> lv;
  assign col_low = up_data.col & (gosa_pkg::IDX_W'(15) >> up_data.elem_size);
  assign s8      = up_data.row[2:0];
  assign s4      = up_data.row[1:0];
  assign c8      = vidx[2:0];
  assign c4      = vidx[1:0];
  assign c16     = up_data.col[3:0];

  // Flat padded offset product; the column is added in the next stage
  assign prod = 22'(up_data.row) * 22'(up_data.padded);

  always_comb begin
    data_nxt.kind     = up_data.kind;
    data_nxt.err      = up_data.err;
    data_nxt.prod     = prod[gosa_pkg::OFF_W-1:0];
    data_nxt.col      = up_data.col;
    data_nxt.tile_col = '0;
    data_nxt.tile_row = '0;
    data_nxt.swz_off  = '0;
    case (up_data.kind)
      gosa_pkg::KIND_FULL: begin
        data_nxt.tile_row = gosa_pkg::TR_W'(up_data.row >> 3);
        data_nxt.tile_col = gosa_pkg::TC_W'(vidx >> 3);
        data_nxt.swz_off  = (gosa_pkg::SWZ_W'({s8, c8 ^ s8}) << lv) | col_low;
      end
      gosa_pkg::KIND_HALF: begin
        data_nxt.tile_row = gosa_pkg::TR_W'(up_data.row >> 3);
        data_nxt.tile_col = gosa_pkg::TC_W'(vidx >> 2);
        data_nxt.swz_off  = (gosa_pkg::SWZ_W'({s8, c4 ^ s8[2:1]}) << lv) | col_low;
      end
      gosa_pkg::KIND_F64_KOUTER: begin
        data_nxt.tile_row = gosa_pkg::TR_W'(up_data.row >> 2);
        data_nxt.tile_col = gosa_pkg::TC_W'(up_data.col >> 4);
        data_nxt.swz_off  = gosa_pkg::SWZ_W'({s4, c16[3:2] ^ s4, c16[1:0]});
      end
      gosa_pkg::KIND_F64_KINNER: begin
        data_nxt.tile_row = gosa_pkg::TR_W'(up_data.row >> 2);
        data_nxt.tile_col = gosa_pkg::TC_W'(up_data.col >> 4);
        data_nxt.swz_off  = gosa_pkg::SWZ_W'({s4, c16[3:2], c16[1:0] ^ s4});
      end
      default: ;
    endcase
  end

  // Advance stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> src/gosa_out.sv
// Stage 3: final offset select, error zeroing and the output register.
// Depends on gosa_pkg for map_t and the layout kinds.
module gosa_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  gosa_pkg::map_t             up_data,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output gosa_pkg::kind_t            kind,
  output logic [gosa_pkg::TC_W-1:0]  tile_col,
  output logic [gosa_pkg::TR_W-1:0]  tile_row,
  output logic [gosa_pkg::OFF_W-1:0] offset,
  output logic                       err
);

  logic                       valid_r;
  gosa_pkg::kind_t            kind_r;
  logic [gosa_pkg::TC_W-1:0]  tile_col_r;
  logic [gosa_pkg::TR_W-1:0]  tile_row_r;
  logic [gosa_pkg::OFF_W-1:0] offset_r;
  logic                       err_r;
  logic [gosa_pkg::OFF_W-1:0] offset_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign kind     = kind_r;
  assign tile_col = tile_col_r;
  assign tile_row = tile_row_r;
  assign offset   = offset_r;
  assign err      = err_r;

  // Padded offset wraps at the field width
  assign offset_nxt = (up_data.kind == gosa_pkg::KIND_PADDED) ?
                      gosa_pkg::OFF_W'(up_data.prod + gosa_pkg::OFF_W'(up_data.col)) :
                      gosa_pkg::OFF_W'(up_data.swz_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load result; drop coordinates on error
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      kind_r     <= up_data.kind;
      err_r      <= up_data.err;
      tile_col_r <= up_data.err ? '0 : up_data.tile_col;
      tile_row_r <= up_data.err ? '0 : up_data.tile_row;
      offset_r   <= up_data.err ? '0 : offset_nxt;
    end
  end

endmodule
